// ===== rtl/imhq_pkg.sv =====
`default_nettype none
package imhq_pkg;
   localparam int unsigned Capacity  = 128;
   localparam int unsigned SlotWidth = 8;
   localparam int unsigned ItemWidth = 7;
   localparam int unsigned KeyWidth  = 32;

   localparam logic [1:0] ModeInsert = 2'd0;
   localparam logic [1:0] ModeDelete = 2'd1;
   localparam logic [1:0] ModeChange = 2'd2;
   localparam logic [1:0] ModeNone   = 2'd3;

   localparam logic [1:0] StatusOk     = 2'd0;
   localparam logic [1:0] StatusFull   = 2'd1;
   localparam logic [1:0] StatusEmpty  = 2'd2;
   localparam logic [1:0] StatusBadIdx = 2'd3;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_LOOK   = 14'b00000000000010,
      ST_DEC    = 14'b00000000000100,
      ST_UPRD   = 14'b00000000001000,
      ST_UPKEY  = 14'b00000000010000,
      ST_UPCMP  = 14'b00000000100000,
      ST_SWAP   = 14'b00000001000000,
      ST_DNRD   = 14'b00000010000000,
      ST_DNKEY  = 14'b00000100000000,
      ST_DNPICK = 14'b00001000000000,
      ST_DNCMP  = 14'b00010000000000,
      ST_TOP    = 14'b00100000000000,
      ST_TOPKEY = 14'b01000000000000,
      ST_OUT    = 14'b10000000000000
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/indexed_max_heap_queue_core.sv =====
// Indexed binary max-heap of up to 128 items (7-bit index, signed 32-bit key). Each
// request beat is one operation: insert, delete maximum, or change key. A small
// sequencer walks the heap one level at a time with one shared signed comparator.
// Going up, each level reads the parent, reads its key, compares and swaps; going
// down, each level reads the children, reads their keys, picks a child, compares and
// swaps. The block takes no new beat until the response beat has been taken.
// Ties never move items. The slot map is cleared at reset through per-item valid bits.
`default_nettype none
module indexed_max_heap_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [6:0]  req_item_index,
   input  wire logic signed [31:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_top_index,
   output logic signed [31:0] rsp_top_key,
   output logic [7:0]       rsp_count,
   output logic [1:0]       rsp_status
);
   localparam int unsigned IW = imhq_pkg::ItemWidth;
   localparam int unsigned SW = imhq_pkg::SlotWidth;
   localparam int unsigned KW = imhq_pkg::KeyWidth;
   localparam int unsigned NI = 1 << IW;

   // stores: heap slots 1..count, keys per item, slot map per item (with valid bits)
   logic [IW-1:0] heap_mem [imhq_pkg::Capacity+1];
   logic [KW-1:0] key_mem [NI];
   logic [SW-1:0] pos_mem [NI];
   logic [NI-1:0] pos_ok_ff, pos_ok_in;

   imhq_pkg::state_type state_ff, state_in;
   logic [1:0]    mode_ff;
   logic [IW-1:0] item_ff;
   logic [KW-1:0] key_ff;
   logic [SW-1:0] count_ff, count_in;
   logic [SW-1:0] cur_ff;      // slot of the moving item
   logic          hit_ff;      // item present at accept
   logic [SW-1:0] lim_ff;      // heap size for sift down
   logic          down_ff;     // change op: sift down after up
   logic          rem_ff;
   logic [1:0]    status_ff;
   // working registers
   logic [IW-1:0] ia_ff, ib_ff, ic_ff; // moving item, parent/left child, right child
   logic [KW-1:0] km_ff, kb_ff, kc_ff; // moving key, parent/chosen key, right key
   logic [SW-1:0] tgt_ff;      // swap partner slot
   logic [IW-1:0] ti_ff;       // partner item
   logic          rvalid_ff;
   logic [IW-1:0] oidx_ff;
   logic [KW-1:0] okey_ff;

   logic [SW-1:0] par, lch, rch;
   logic [SW:0]   lch_w;
   logic [KW-1:0] cmp_a, cmp_b;
   logic          cmp_lt;
   logic          right_ok;
   logic          pick_right;

   always_comb begin
      par = cur_ff >> 1;
      lch = SW'(cur_ff << 1);
      rch = lch | SW'(1);
   end
   always_comb lch_w = {cur_ff, 1'b0};

   // shared comparator: signed a < b
   //  up:        parent key < moving key
   //  pick:      left key < right key
   //  down:      moving key < chosen child key
   always_comb begin
      cmp_a = kb_ff;
      cmp_b = km_ff;
      case (state_ff)
         imhq_pkg::ST_DNPICK: cmp_b = kc_ff;
         imhq_pkg::ST_DNCMP: begin
            cmp_a = km_ff;
            cmp_b = kb_ff;
         end
         default: ;
      endcase
   end
   always_comb cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   // right child only counts when it lies inside the heap; ties keep the left
   always_comb begin
      right_ok = rch <= lim_ff;
      pick_right = right_ok && cmp_lt;
   end

   assign req_ready = (state_ff == imhq_pkg::ST_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_top_index = oidx_ff;
   assign rsp_top_key   = okey_ff;
   assign rsp_count     = count_ff;
   assign rsp_status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imhq_pkg::ST_IDLE;
         count_ff <= '0;
         pos_ok_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ok_ff <= pos_ok_in;
         if (state_ff == imhq_pkg::ST_OUT) rvalid_ff <= 1'b1;
         else if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_ok_in = pos_ok_ff;
      case (state_ff)
         imhq_pkg::ST_IDLE: if (req_valid && req_ready) state_in = imhq_pkg::ST_LOOK;
         imhq_pkg::ST_LOOK: begin
            state_in = imhq_pkg::ST_TOP;
            case (mode_ff)
               imhq_pkg::ModeInsert: begin
                  if (count_ff < SW'(imhq_pkg::Capacity) && !hit_ff) begin
                     count_in = count_ff + SW'(1);
                     pos_ok_in[item_ff] = 1'b1;
                     state_in = imhq_pkg::ST_UPRD;
                  end
               end
               imhq_pkg::ModeDelete: if (count_ff != '0) state_in = imhq_pkg::ST_DEC;
               imhq_pkg::ModeChange: if (hit_ff) state_in = imhq_pkg::ST_UPRD;
               default: ;
            endcase
         end
         imhq_pkg::ST_DEC: begin
            state_in = imhq_pkg::ST_DNRD;
            count_in = count_ff - SW'(1);
            pos_ok_in[ia_ff] = 1'b0;
         end
         imhq_pkg::ST_UPRD: state_in = (cur_ff > SW'(1)) ? imhq_pkg::ST_UPKEY :
                                        (down_ff ? imhq_pkg::ST_DNRD : imhq_pkg::ST_TOP);
         imhq_pkg::ST_UPKEY: state_in = imhq_pkg::ST_UPCMP;
         imhq_pkg::ST_UPCMP: state_in = cmp_lt ? imhq_pkg::ST_SWAP :
                                        (down_ff ? imhq_pkg::ST_DNRD : imhq_pkg::ST_TOP);
         imhq_pkg::ST_SWAP: state_in = (tgt_ff < cur_ff) ? imhq_pkg::ST_UPRD
                                                         : imhq_pkg::ST_DNRD;
         imhq_pkg::ST_DNRD: state_in = ({1'b0, lim_ff} >= lch_w) ? imhq_pkg::ST_DNKEY
                                                                  : imhq_pkg::ST_TOP;
         imhq_pkg::ST_DNKEY: state_in = imhq_pkg::ST_DNPICK;
         imhq_pkg::ST_DNPICK: state_in = imhq_pkg::ST_DNCMP;
         imhq_pkg::ST_DNCMP: state_in = cmp_lt ? imhq_pkg::ST_SWAP : imhq_pkg::ST_TOP;
         imhq_pkg::ST_TOP: state_in = imhq_pkg::ST_TOPKEY;
         imhq_pkg::ST_TOPKEY: state_in = imhq_pkg::ST_OUT;
         imhq_pkg::ST_OUT: state_in = imhq_pkg::ST_IDLE;
         default: state_in = imhq_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         imhq_pkg::ST_IDLE: begin
            mode_ff <= req_mode; item_ff <= req_item_index; key_ff <= req_key;
            cur_ff <= pos_mem[req_item_index];
            hit_ff <= pos_ok_ff[req_item_index];
            rem_ff <= 1'b0; down_ff <= 1'b0;
         end
         imhq_pkg::ST_LOOK: begin
            case (mode_ff)
               imhq_pkg::ModeInsert: begin
                  if (count_ff >= SW'(imhq_pkg::Capacity)) status_ff <= imhq_pkg::StatusFull;
                  else if (hit_ff) status_ff <= imhq_pkg::StatusBadIdx;
                  else begin
                     status_ff <= imhq_pkg::StatusOk;
                     key_mem[item_ff] <= key_ff;
                     heap_mem[count_ff + SW'(1)] <= item_ff;
                     pos_mem[item_ff] <= count_ff + SW'(1);
                     cur_ff <= count_ff + SW'(1);
                     ia_ff <= item_ff;
                     km_ff <= key_ff;
                  end
               end
               imhq_pkg::ModeDelete: begin
                  if (count_ff == '0) status_ff <= imhq_pkg::StatusEmpty;
                  else begin
                     // removed root held in ia, last item in ib
                     status_ff <= imhq_pkg::StatusOk;
                     ia_ff <= heap_mem[1];
                     ib_ff <= heap_mem[count_ff];
                     rem_ff <= 1'b1;
                  end
               end
               imhq_pkg::ModeChange: begin
                  if (!hit_ff) status_ff <= imhq_pkg::StatusBadIdx;
                  else begin
                     status_ff <= imhq_pkg::StatusOk;
                     key_mem[item_ff] <= key_ff;
                     ia_ff <= item_ff;
                     km_ff <= key_ff;
                     down_ff <= 1'b1;
                  end
               end
               default: status_ff <= imhq_pkg::StatusOk;
            endcase
         end
         imhq_pkg::ST_DEC: begin
            // last item goes to the root and becomes the moving item
            heap_mem[1] <= ib_ff;
            pos_mem[ib_ff] <= SW'(1);
            oidx_ff <= ia_ff;
            okey_ff <= key_mem[ia_ff];
            km_ff <= key_mem[ib_ff];
            ia_ff <= ib_ff;
            cur_ff <= SW'(1);
            lim_ff <= count_ff - SW'(1);
         end
         imhq_pkg::ST_UPRD: begin
            ib_ff <= heap_mem[par];
            tgt_ff <= par;
            lim_ff <= count_ff;
         end
         imhq_pkg::ST_UPKEY: begin
            kb_ff <= key_mem[ib_ff];
            ti_ff <= ib_ff;
         end
         imhq_pkg::ST_SWAP: begin
            heap_mem[cur_ff] <= ti_ff;
            heap_mem[tgt_ff] <= ia_ff;
            pos_mem[ti_ff] <= cur_ff;
            pos_mem[ia_ff] <= tgt_ff;
            cur_ff <= tgt_ff;
         end
         imhq_pkg::ST_DNRD: begin
            ib_ff <= heap_mem[lch];
            ic_ff <= heap_mem[rch];
         end
         imhq_pkg::ST_DNKEY: begin
            kb_ff <= key_mem[ib_ff];
            kc_ff <= key_mem[ic_ff];
         end
         imhq_pkg::ST_DNPICK: begin
            if (pick_right) begin
               tgt_ff <= rch;
               ti_ff <= ic_ff;
               kb_ff <= kc_ff;
            end else begin
               tgt_ff <= lch;
               ti_ff <= ib_ff;
            end
         end
         imhq_pkg::ST_TOP: ib_ff <= heap_mem[1];
         imhq_pkg::ST_TOPKEY: begin
            if (!rem_ff) begin
               oidx_ff <= (count_ff != '0) ? ib_ff : '0;
               okey_ff <= (count_ff != '0) ? key_mem[ib_ff] : '0;
            end
         end
         default: ;
      endcase
   end

   // assertions
   property p_count_cap;
      @(posedge clock) disable iff (reset) count_ff <= SW'(imhq_pkg::Capacity);
   endproperty
   a_count_cap: assert property (p_count_cap) else $error("count above capacity");
   a_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> !req_ready) else $error("ready while response pending");
   a_state_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_index)
      && $stable(rsp_top_key) && $stable(rsp_count) && $stable(rsp_status))
      else $error("response beat changed while waiting");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 2_000_000;
   localparam int unsigned DrainCycles = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = imhq_pkg::ModeInsert;
   logic [6:0] req_item_index = '0;
   logic signed [31:0] req_key = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_top_index;
   logic signed [31:0] rsp_top_key;
   logic [7:0] rsp_count;
   logic [1:0] rsp_status;

   indexed_max_heap_queue_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_item_index(req_item_index), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_top_index(rsp_top_index),
      .rsp_top_key(rsp_top_key), .rsp_count(rsp_count), .rsp_status(rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      logic [6:0] top_index;
      logic signed [31:0] top_key;
      logic [7:0] count;
      logic [1:0] status;
   } heap_result_type;

   // predictor copy of the heap; slot 0 unused, item_slot 0 means absent
   logic [6:0] model_heap [1:imhq_pkg::Capacity];
   logic [7:0] item_slot [0:127];
   logic signed [31:0] item_key [0:127];
   int unsigned model_count;

   heap_result_type pending_results [$];
   int unsigned error_count = 0;
   int unsigned result_count = 0;
   int unsigned beats_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned status_seen [4];
   bit hold_off = 1'b0;
   bit rsp_stall_on = 1'b1;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h want %0h", result_count, what, got, want);
      error_count++;
   endtask

   function automatic bit key_below(input logic [6:0] a, input logic [6:0] b);
      return item_key[a] < item_key[b];
   endfunction

   function automatic void swap_heap(input int unsigned s, input int unsigned t);
      logic [6:0] a, b;
      a = model_heap[s];
      b = model_heap[t];
      model_heap[s] = b;
      model_heap[t] = a;
      item_slot[b] = s[7:0];
      item_slot[a] = t[7:0];
   endfunction

   function automatic void heap_rise(input int unsigned start);
      int unsigned s;
      s = start;
      while (s > 1 && key_below(model_heap[s / 2], model_heap[s])) begin
         swap_heap(s, s / 2);
         s = s / 2;
      end
   endfunction

   function automatic void heap_sink(input int unsigned start, input int unsigned n);
      int unsigned s, c;
      s = start;
      while (2 * s <= n) begin
         c = 2 * s;
         if (c < n && key_below(model_heap[c], model_heap[c + 1])) c++;
         if (!key_below(model_heap[s], model_heap[c])) break;
         swap_heap(s, c);
         s = c;
      end
   endfunction

   // works out the response for one accepted operation and updates the copy
   function automatic heap_result_type apply_heap_op(input logic [1:0] mode,
                                                     input logic [6:0] item,
                                                     input logic signed [31:0] key);
      heap_result_type r;
      bit removed;
      logic [6:0] gone;
      removed = 1'b0;
      gone = '0;
      r.status = imhq_pkg::StatusOk;
      if (mode == imhq_pkg::ModeInsert) begin
         if (model_count >= imhq_pkg::Capacity) r.status = imhq_pkg::StatusFull;
         else if (item_slot[item] != 0) r.status = imhq_pkg::StatusBadIdx;
         else begin
            item_key[item] = key;
            model_count++;
            item_slot[item] = model_count[7:0];
            model_heap[model_count] = item;
            heap_rise(model_count);
         end
      end else if (mode == imhq_pkg::ModeDelete) begin
         if (model_count == 0) r.status = imhq_pkg::StatusEmpty;
         else begin
            swap_heap(1, model_count);
            heap_sink(1, model_count - 1);
            gone = model_heap[model_count];
            item_slot[gone] = '0;
            model_count--;
            removed = 1'b1;
         end
      end else if (mode == imhq_pkg::ModeChange) begin
         if (item_slot[item] == 0) r.status = imhq_pkg::StatusBadIdx;
         else begin
            item_key[item] = key;
            heap_rise(item_slot[item]);
            heap_sink(item_slot[item], model_count);
         end
      end
      if (removed) begin
         r.top_index = gone;
         r.top_key = item_key[gone];
      end else if (model_count != 0) begin
         r.top_index = model_heap[1];
         r.top_key = item_key[model_heap[1]];
      end else begin
         r.top_index = '0;
         r.top_key = '0;
      end
      r.count = model_count[7:0];
      return r;
   endfunction

   // one beat; bursts and gaps decided by the caller via idle_cycles
   task automatic send_op(input logic [1:0] mode, input logic [6:0] item,
                          input logic signed [31:0] key, input int unsigned idle_cycles);
      if (idle_cycles != 0) begin
         req_valid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_item_index <= item;
      req_key <= key;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_heap_op(mode, item, key));
      beats_sent++;
   endtask

   int unsigned burst_left = 0;
   function automatic int unsigned next_gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         return $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      end
      burst_left--;
      return 0;
   endfunction

   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(0, 7))) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   // receiver: own stall pattern, or a long hold-off while hold_off is set
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else if (rsp_stall_on) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("unexpected response beat: index %0h key %0h", rsp_top_index,
                     rsp_top_key);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_top_index !== want.top_index)
               report_mismatch("top_index", 32'(rsp_top_index), 32'(want.top_index));
            if (rsp_top_key !== want.top_key)
               report_mismatch("top_key", rsp_top_key, want.top_key);
            if (rsp_count !== want.count)
               report_mismatch("count", 32'(rsp_count), 32'(want.count));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            status_seen[want.status]++;
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // directed: empty/bad index, ties, extremes, unused mode, reinsert
   task automatic test_directed();
      send_op(imhq_pkg::ModeDelete, 7'd0, 0, 0);
      send_op(imhq_pkg::ModeChange, 7'd5, 1, 0);
      send_op(imhq_pkg::ModeNone, 7'h7f, 32'sh7fff_ffff, 0);
      send_op(imhq_pkg::ModeInsert, 7'd0, 32'sh8000_0000, 0);
      send_op(imhq_pkg::ModeInsert, 7'h7f, 32'sh7fff_ffff, 1);
      send_op(imhq_pkg::ModeInsert, 7'd0, 5, 0);
      send_op(imhq_pkg::ModeInsert, 7'h2a, 32'sh7fff_ffff, 0);
      send_op(imhq_pkg::ModeInsert, 7'h55, 0, 2);
      send_op(imhq_pkg::ModeInsert, 7'h11, -1, 0);
      send_op(imhq_pkg::ModeNone, 7'd0, 0, 0);
      send_op(imhq_pkg::ModeChange, 7'd0, 32'sh7fff_ffff, 0);
      send_op(imhq_pkg::ModeChange, 7'h7f, 32'sh8000_0000, 0);
      send_op(imhq_pkg::ModeChange, 7'h33, 9, 0);
      repeat (3) send_op(imhq_pkg::ModeDelete, 7'd0, 0, 0);
      send_op(imhq_pkg::ModeInsert, 7'h7f, 1, 0);
      repeat (4) send_op(imhq_pkg::ModeDelete, 7'h7f, 0, 0);
   endtask

   // fills all 128 slots, pokes full, then drains; receiver held off for a while
   task automatic test_fill_and_drain();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int i = 0; i < 128; i++)
         send_op(imhq_pkg::ModeInsert, 7'(i ^ 7'h35), pick_key(), 0);
      send_op(imhq_pkg::ModeInsert, 7'd3, 1, 0);
      send_op(imhq_pkg::ModeInsert, 7'h7f, 1, 0);
      for (int i = 0; i < 20; i++)
         send_op(imhq_pkg::ModeChange, 7'($urandom_range(0, 127)), pick_key(), next_gap());
      for (int i = 0; i < 130; i++) send_op(imhq_pkg::ModeDelete, 7'd0, 0, next_gap());
   endtask

   // random mix weighted to keep the heap well populated
   task automatic test_random_mix(input int unsigned beats);
      logic [1:0] mode;
      int unsigned pick;
      for (int unsigned i = 0; i < beats; i++) begin
         if (i == beats / 2) rsp_stall_on = 1'b0;
         if (i == 3 * beats / 4) rsp_stall_on = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45) mode = imhq_pkg::ModeInsert;
         else if (pick < 70) mode = imhq_pkg::ModeDelete;
         else if (pick < 97) mode = imhq_pkg::ModeChange;
         else mode = imhq_pkg::ModeNone;
         send_op(mode, 7'($urandom()), pick_key(), next_gap());
      end
   endtask

   initial begin
      for (int i = 0; i < 128; i++) begin
         item_slot[i] = '0;
         item_key[i] = '0;
      end
      model_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_random_mix(1300);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d operations sent, %0d responses checked", beats_sent, result_count);
      $display("statuses ok %0d full %0d empty %0d bad-index %0d",
               status_seen[imhq_pkg::StatusOk], status_seen[imhq_pkg::StatusFull],
               status_seen[imhq_pkg::StatusEmpty], status_seen[imhq_pkg::StatusBadIdx]);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
